### rtl/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared constants and types for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int VALUE_WIDTH = 32;
  // floor(W * log10(2)) + 1 decimal digits cover any W-bit magnitude
  localparam int DEC_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int REM_W       = $clog2(DEC_DIGITS + 1);

  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

  typedef struct packed {
    logic clear;  // load zero
    logic conv;   // add-3 and shift in one binary bit
    logic shift;  // move digit one cell toward the top
  } sbda_ctrl_t;

endpackage

### rtl/sbda_cell.sv
// ----------------------------------------------------------------------------
// sbda_cell
// One BCD digit of the shift-add-3 chain; also shifts digits out to the top.
// ----------------------------------------------------------------------------
module sbda_cell
  import sbda_pkg::*;
(
  input  logic       clk,
  input  sbda_ctrl_t ctrl,
  input  logic       bit_in,
  input  logic [3:0] digit_in,
  output logic       bit_out,
  output logic [3:0] digit
);

  logic [3:0] adj;

  assign adj     = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  assign bit_out = adj[3];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= 4'd0;
    end else if (ctrl.conv) begin
      digit <= {adj[2:0], bit_in};
    end else if (ctrl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

### rtl/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Signed integer to decimal ASCII text, one character per output transaction.
// ----------------------------------------------------------------------------
// Flow: a value is accepted only while idle. It is converted bit-serially by
//   the digit cell chain, leading zeros are skipped, a minus sign is sent for
//   a negative value and the digits follow, each held while out_stall is high.
//   in_stall stays high until the last digit of the text has been issued.
// Reset: synchronous, clears the control state and the output valid.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii
  import sbda_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [5:0]             char_code,
  output logic                   last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;
  logic [CNT_W-1:0]       cnt;
  logic [REM_W-1:0]       rem;
  sbda_ctrl_t             ctrl;
  logic                   in_take;
  logic                   out_free;
  logic [DEC_DIGITS:0]    carry;
  logic [3:0]             dig [DEC_DIGITS];
  logic [3:0]             top;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign top      = dig[DEC_DIGITS-1];
  assign carry[0] = mag[VALUE_WIDTH-1];

  always_comb begin
    ctrl       = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          ctrl.clear = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.conv = 1'b1;
        if (cnt == CNT_W'(VALUE_WIDTH - 1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top == 4'd0 && rem > REM_W'(1)) begin
          ctrl.shift = 1'b1;
        end else begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ctrl.shift = 1'b1;
          if (rem == REM_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < DEC_DIGITS; i++) begin : g_cell
    sbda_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (carry[i]),
      .digit_in ((i == 0) ? 4'd0 : dig[(i == 0) ? 0 : i - 1]),
      .bit_out  (carry[i+1]),
      .digit    (dig[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      neg <= value[VALUE_WIDTH-1];
      mag <= value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
      cnt <= '0;
    end else if (ctrl.conv) begin
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end
    if (ctrl.conv && cnt == CNT_W'(VALUE_WIDTH - 1)) begin
      rem <= REM_W'(DEC_DIGITS);
    end else if (ctrl.shift) begin
      rem <= rem - REM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free && (state == ST_SIGN || state == ST_EMIT)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && state == ST_SIGN) begin
      char_code <= CHAR_MINUS;
      last      <= 1'b0;
    end else if (out_free && state == ST_EMIT) begin
      char_code <= CHAR_ZERO + {2'b00, top};
      last      <= (rem == REM_W'(1));
    end
  end

  a_take_conv: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == ST_CONV)
    else $error("accepted value did not start conversion");

  a_top_bcd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP || state == ST_EMIT) |-> top <= 4'd9)
    else $error("top digit is not a decimal digit");

  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP || state == ST_SIGN || state == ST_EMIT) |-> rem != '0)
    else $error("digit count ran out");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free && rem == REM_W'(1)) |=> state == ST_IDLE && last)
    else $error("final digit did not end the text");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == CHAR_MINUS ||
                   (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 6'd9)))
    else $error("character out of range");

endmodule
